FILE: src/wbps_pkg.sv
// Shared types and codes for the wildcard byte pattern scanner.
// No dependencies.
package wbps_pkg;

	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_APPEND = 2'd1;
	localparam logic [1:0] FUNC_SCAN   = 2'd2;

	localparam int ADDR_W = 64;

	// one pattern element: wildcard flag and byte value
	typedef struct packed {
		logic       wild;
		logic [7:0] value;
	} wbps_elem_t;

	// per-item command from the top level to the matcher
	typedef struct packed {
		logic clear;
		logic append;
		logic shift;
	} wbps_cmd_t;

endpackage

FILE: src/wildcard_byte_pattern_scanner.sv
// Wildcard byte pattern scanner, top level.
// Uses wbps_pkg and wbps_matcher.
//
// Usage: items enter on in_valid/in_stall with func, pattern_byte,
// is_wildcard, data_byte and is_last. func CLEAR empties the pattern and
// restarts the region scan, APPEND adds one element (wildcard or byte),
// SCAN feeds one region byte. Results leave on out_valid/out_stall as
// found and match_address: one result at the first full match (base plus
// start offset), or found=0 with address zero when the last byte passes
// without a match. Matching is off while region_base is zero, the pattern
// is empty, or the pattern overflowed. region_base is written through
// cfg_we/cfg_wdata by the user while the block is idle; not enforced.
//
// Throughput: one item per cycle while in_stall is low; every position
// of the pattern is compared in parallel against a shift window of recent
// bytes. A result passes the input register, the compare stage and the
// output register. Reset clears the pattern count, overflow flag, scan
// state, base and all valid flags. While out_stall is high the result is
// held; the pipeline keeps filling behind it and in_stall rises once no
// slot is free.
module wildcard_byte_pattern_scanner import wbps_pkg::*; #(
	parameter int MAX_PATTERN = 32,
	parameter int OFFSET_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        func,
	input  logic [7:0]        pattern_byte,
	input  logic              is_wildcard,
	input  logic [7:0]        data_byte,
	input  logic              is_last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              found,
	output logic [ADDR_W-1:0] match_address
);

	localparam int CNT_W = $clog2(MAX_PATTERN + 1);

	logic [ADDR_W-1:0]      base_q;

	// input register
	logic                   valid_s1;
	logic [1:0]             func_s1;
	wbps_elem_t             elem_s1;
	logic [7:0]             data_s1;
	logic                   last_s1;

	// scan state
	logic [OFFSET_BITS-1:0] seen_q;
	logic                   rep_q;

	// compare stage result
	logic                   res_valid_s2;
	logic                   found_s2;
	logic [OFFSET_BITS-1:0] off_s2;

	logic                   adv1;
	logic                   adv2;
	logic                   fire;
	wbps_cmd_t              cmd;
	logic                   hit;
	logic [CNT_W-1:0]       count;
	logic [OFFSET_BITS-1:0] seen_nx;
	logic [OFFSET_BITS-1:0] cnt_ext;
	logic                   match_now;
	logic                   miss_now;

	assign adv2     = !out_valid || !out_stall;
	assign adv1     = !res_valid_s2 || adv2;
	assign fire     = valid_s1 && adv1;
	assign in_stall = valid_s1 && !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1  <= func;
			elem_s1  <= '{wild: is_wildcard, value: pattern_byte};
			data_s1  <= data_byte;
			last_s1  <= is_last;
		end
	end

	always_comb begin
		cmd = '0;
		if (fire) begin
			case (func_s1)
				FUNC_CLEAR:  cmd.clear  = 1'b1;
				FUNC_APPEND: cmd.append = 1'b1;
				FUNC_SCAN:   cmd.shift  = 1'b1;
				default:     cmd        = '0;
			endcase
		end
	end

	wbps_matcher #(
		.MAX_PATTERN(MAX_PATTERN),
		.CNT_W      (CNT_W)
	) u_matcher (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.elem     (elem_s1),
		.data_byte(data_s1),
		.hit      (hit),
		.count    (count)
	);

	// byte count saturates at all ones
	assign seen_nx   = (&seen_q) ? seen_q : seen_q + 1'b1;
	assign cnt_ext   = OFFSET_BITS'(count);
	assign match_now = cmd.shift && hit && (seen_nx >= cnt_ext) &&
		(base_q != '0) && !rep_q;
	assign miss_now  = cmd.shift && !match_now && last_s1 && !rep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			rep_q  <= 1'b0;
		end else if (cmd.clear || (cmd.shift && last_s1)) begin
			seen_q <= '0;
			rep_q  <= 1'b0;
		end else if (cmd.shift) begin
			seen_q <= seen_nx;
			rep_q  <= rep_q || match_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (adv1) begin
			res_valid_s2 <= match_now || miss_now;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			found_s2 <= match_now;
			off_s2   <= seen_nx - cnt_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv2) begin
			out_valid <= res_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			found         <= found_s2;
			match_address <= found_s2 ? (base_q + ADDR_W'(off_s2)) : '0;
		end
	end

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_address == '0)
		else $error("miss result with nonzero address");

	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		rep_q |-> !match_now)
		else $error("second match reported in one region");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && res_valid_s2 && out_valid && out_stall)
		else $error("input stalled with a free slot");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && !adv2 |=> res_valid_s2 && $stable(off_s2) && $stable(found_s2))
		else $error("compare stage result lost under stall");

endmodule

FILE: src/wbps_matcher.sv
// Pattern store, byte window and parallel compare for the pattern scanner.
// Depends on wbps_pkg.
module wbps_matcher import wbps_pkg::*; #(
	parameter int MAX_PATTERN = 32,
	parameter int CNT_W       = $clog2(MAX_PATTERN + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  wbps_cmd_t        cmd,
	input  wbps_elem_t       elem,
	input  logic [7:0]       data_byte,
	output logic             hit,
	output logic [CNT_W-1:0] count
);

	// Pattern is held reversed: the newest element sits at lane 0, so lane j
	// always lines up with window lane j (newest byte first).
	wbps_elem_t       store_q [MAX_PATTERN];
	logic [7:0]       win_q   [MAX_PATTERN];
	logic [7:0]       win_nx  [MAX_PATTERN];
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [MAX_PATTERN-1:0] lane_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.clear) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.append) begin
			if (count_q < CNT_W'(MAX_PATTERN)) begin
				count_q <= count_q + 1'b1;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append && (count_q < CNT_W'(MAX_PATTERN))) begin
			store_q[0] <= elem;
			for (int k = 1; k < MAX_PATTERN; k++) begin
				store_q[k] <= store_q[k-1];
			end
		end
		if (cmd.shift) begin
			win_q <= win_nx;
		end
	end

	always_comb begin
		win_nx[0] = data_byte;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			win_nx[k] = win_q[k-1];
		end
	end

	// lanes past the element count are don't-care
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_lane
		assign lane_ok[j] = (count_q <= CNT_W'(j)) || store_q[j].wild ||
			(store_q[j].value == win_nx[j]);
	end

	assign hit   = (count_q != '0) && !ovf_q && (&lane_ok);
	assign count = count_q;

endmodule

FILE: verif/wildcard_byte_pattern_scanner_test.sv
// Self-checking testbench for the wildcard byte pattern scanner.
// Depends on wbps_pkg and wildcard_byte_pattern_scanner; the expected results
// are computed in step with accepted items and checked in order.
module wildcard_byte_pattern_scanner_test import wbps_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PAT = 32;
	localparam int LIMIT_CYCLES = 400000;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] address;
	} scan_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [ADDR_W-1:0] cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        func = FUNC_CLEAR;
	logic [7:0]        pattern_byte = '0;
	logic              is_wildcard = 1'b0;
	logic [7:0]        data_byte = '0;
	logic              is_last = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              found;
	logic [ADDR_W-1:0] match_address;

	// scanner state as the testbench sees it
	logic [ADDR_W-1:0] base_q = '0;
	wbps_elem_t        pat_mem [MAX_PAT];
	int                pat_len = 0;
	bit                pat_over = 1'b0;
	logic [7:0]        recent [MAX_PAT];
	logic [31:0]       seen = '0;
	bit                reported = 1'b0;
	scan_result_t      pending_results [$];

	int fail_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int matches_seen = 0;
	int hold_request = 0;
	bit quiet = 1'b0;

	wildcard_byte_pattern_scanner #(
		.MAX_PATTERN(MAX_PAT),
		.OFFSET_BITS(32)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.pattern_byte (pattern_byte),
		.is_wildcard  (is_wildcard),
		.data_byte    (data_byte),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.match_address(match_address)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void restart_window();
		foreach (recent[k]) recent[k] = '0;
		seen = '0;
		reported = 1'b0;
	endfunction

	function automatic void predict_scanner_item(input logic [1:0] f, input logic [7:0] pb,
			input logic w, input logic [7:0] db, input logic l);
		scan_result_t r;
		bit enabled;
		bit hit;
		case (f)
			FUNC_CLEAR: begin
				pat_len = 0;
				pat_over = 1'b0;
				restart_window();
			end
			FUNC_APPEND: begin
				if (pat_len < MAX_PAT) begin
					pat_mem[pat_len].wild = w;
					pat_mem[pat_len].value = pb;
					pat_len++;
				end else begin
					pat_over = 1'b1;
				end
			end
			FUNC_SCAN: begin
				enabled = pat_len != 0 && !pat_over && base_q != '0;
				for (int k = MAX_PAT - 1; k > 0; k--) recent[k] = recent[k - 1];
				recent[0] = db;
				if (seen != '1) seen++;
				// oldest window byte lines up with the first pattern element
				hit = pat_len != 0 && seen >= 32'(pat_len);
				for (int i = 0; i < pat_len; i++)
					if (!pat_mem[i].wild && pat_mem[i].value != recent[pat_len - 1 - i])
						hit = 1'b0;
				if (enabled && !reported && hit) begin
					r.found = 1'b1;
					r.address = base_q + ADDR_W'(seen - 32'(pat_len));
					reported = 1'b1;
					pending_results = {pending_results, r};
				end else if (l && !reported) begin
					r.found = 1'b0;
					r.address = '0;
					pending_results = {pending_results, r};
				end
				if (l) restart_window();
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(input logic [1:0] f, input logic [7:0] pb, input logic w,
			input logic [7:0] db, input logic l);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		func <= f;
		pattern_byte <= pb;
		is_wildcard <= w;
		data_byte <= db;
		is_last <= l;
		do @(posedge clk); while (in_stall);
		predict_scanner_item(f, pb, w, db, l);
		if (f != FUNC_UNUSED) items_sent++;
		gap = quiet ? 0 : gap_len();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic do_clear();
		send_item(FUNC_CLEAR, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
	endtask

	task automatic do_append(input logic [7:0] b, input logic w);
		send_item(FUNC_APPEND, b, w, 8'($urandom), 1'($urandom));
	endtask

	task automatic do_scan(input logic [7:0] b, input logic l);
		send_item(FUNC_SCAN, 8'($urandom), 1'($urandom), b, l);
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		// items with no result may still be in flight
		repeat (8) @(negedge clk);
	endtask

	task automatic write_region_base(input logic [ADDR_W-1:0] v);
		drain_pipeline();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		base_q = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_pattern(input int n, input int wild_pct, input bit fresh);
		if (fresh) do_clear();
		repeat (n) do_append(8'($urandom), $urandom_range(0, 99) < wild_pct);
	endtask

	// one region; plant drops a copy of the current pattern at a random spot
	task automatic scan_region(input int len, input bit plant, input bit close);
		int at;
		logic [7:0] b;
		if (plant && pat_len != 0 && pat_len <= len) at = $urandom_range(0, len - pat_len);
		else at = -1;
		for (int i = 0; i < len; i++) begin
			if (at >= 0 && i >= at && i < at + pat_len && !pat_mem[i - at].wild)
				b = pat_mem[i - at].value;
			else if (pat_len != 0 && $urandom_range(0, 1))
				b = pat_mem[$urandom_range(0, pat_len - 1)].value;
			else
				b = 8'($urandom);
			if ($urandom_range(0, 39) == 0)
				send_item(FUNC_UNUSED, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
			do_scan(b, close && i == len - 1);
		end
	endtask

	task automatic test_disabled_paths();
		// base is still zero from reset
		do_scan(8'h00, 1'b1);
		do_append(8'hAB, 1'b0);
		do_scan(8'hAB, 1'b1);
	endtask

	task automatic test_directed_matches();
		write_region_base('1);
		do_clear();
		do_append(8'h00, 1'b0);
		do_append(8'h5A, 1'b1);
		do_append(8'hFF, 1'b0);
		do_scan(8'h00, 1'b0);
		do_scan(8'h13, 1'b0);
		do_scan(8'hFF, 1'b0);
		// already matched: the rest of the region is silent
		do_scan(8'h00, 1'b0);
		do_scan(8'hFF, 1'b1);
		// match ends on the last byte, base + 1 wraps to zero
		do_scan(8'h11, 1'b0);
		do_scan(8'h00, 1'b0);
		do_scan(8'h80, 1'b0);
		do_scan(8'hFF, 1'b1);
		send_item(FUNC_UNUSED, 8'hFF, 1'b1, 8'hFF, 1'b1);
		do_scan(8'hFF, 1'b1);
		// clear in the middle of a region restarts the scan
		do_scan(8'h42, 1'b0);
		do_clear();
		do_append(8'h42, 1'b0);
		do_scan(8'h42, 1'b1);
	endtask

	task automatic test_store_limits();
		write_region_base(64'h1);
		load_pattern(MAX_PAT + 1, 30, 1'b1);
		scan_region(40, 1'b1, 1'b1);
		load_pattern(MAX_PAT, 20, 1'b1);
		scan_region(48, 1'b1, 1'b1);
	endtask

	task automatic test_backpressure();
		write_region_base(64'h0000_1000_0000_0000);
		do_clear();
		do_append(8'h00, 1'b1);
		quiet = 1'b1;
		hold_request = 200;
		// every single-byte region matches, so each item gives a result
		repeat (60) do_scan(8'($urandom), 1'b1);
		quiet = 1'b0;
	endtask

	task automatic test_random_regions();
		logic [ADDR_W-1:0] bases [6];
		int phase_end;
		int n;
		int sel;
		int len;
		bases[0] = 64'h1;
		bases[1] = {$urandom, $urandom};
		bases[2] = 64'h8000_0000_0000_0000;
		bases[3] = 64'hFFFF_FFFF_FFFF_FFF0;
		bases[4] = '0;
		bases[5] = {$urandom, $urandom};
		for (int p = 0; p < 6; p++) begin
			write_region_base(bases[p]);
			phase_end = items_sent + 80;
			while (items_sent < phase_end) begin
				quiet = $urandom_range(0, 4) == 0;
				if ($urandom_range(0, 99) < 12) begin
					repeat ($urandom_range(3, 10))
						send_item(2'($urandom), 8'($urandom), 1'($urandom),
							8'($urandom), 1'($urandom));
				end else begin
					sel = $urandom_range(0, 99);
					if (sel < 80) n = $urandom_range(1, 6);
					else if (sel < 94) n = $urandom_range(7, MAX_PAT);
					else n = $urandom_range(MAX_PAT + 1, MAX_PAT + 3);
					load_pattern(n, 25, $urandom_range(0, 9) != 0);
					repeat ($urandom_range(1, 4)) begin
						if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 80);
						else len = pat_len + $urandom_range(0, 16);
						if (len == 0) len = 1;
						scan_region(len, $urandom_range(0, 99) < 65,
							$urandom_range(0, 9) != 0);
					end
				end
				quiet = 1'b0;
			end
		end
	endtask

	// receiver: random stalls, quiet stretches and a long hold on request
	initial begin
		int stall_run;
		int hold_left;
		stall_run = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else if (stall_run > 0) begin
				stall_run--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 99) < 20) begin
				stall_run = gap_len();
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: found %0b match_address %h", found, match_address);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (want.found) matches_seen++;
				if (found !== want.found) begin
					$error("found: expected %0b, actual %0b", want.found, found);
					fail_count++;
				end
				if (match_address !== want.address) begin
					$error("match_address: expected %h, actual %h", want.address,
						match_address);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles,
			pending_results.size());
		$display("** wildcard_byte_pattern_scanner: FAILED **");
		$finish;
	end

	initial begin
		restart_window();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_disabled_paths();
		test_directed_matches();
		test_store_limits();
		test_backpressure();
		test_random_regions();
		drain_pipeline();
		$display("%0d items sent, %0d results checked, %0d of them matches", items_sent,
			results_checked, matches_seen);
		$display("covered disabled scans, wildcards, address wrap, store overflow and a long hold");
		if (fail_count == 0)
			$display("** wildcard_byte_pattern_scanner: PASSED **");
		else
			$display("** wildcard_byte_pattern_scanner: FAILED **");
		$finish;
	end

endmodule

FILE: sim.f
src/wbps_pkg.sv
src/wbps_matcher.sv
src/wildcard_byte_pattern_scanner.sv
verif/wildcard_byte_pattern_scanner_test.sv
